### hw/rtl/cpmd_pkg.sv
`default_nettype none

package cpmd_pkg;

   // Fixed field widths of the channels
   localparam int COORD_FIELD_W = 10;
   localparam int DIST_FIELD_W  = 21;

   // Defaults for the top-level parameters
   localparam int MAX_POINTS_DEF = 128;
   localparam int COORD_BITS_DEF = 10;

endpackage

`default_nettype wire

### hw/rtl/cpmd_if.sv
`default_nettype none

// Point beat: one 2-D point, last_point closes the set
interface cpmd_req_if import cpmd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [COORD_FIELD_W-1:0] px;
   logic [COORD_FIELD_W-1:0] py;
   logic                     last_point;

   modport source (output valid, output px, output py, output last_point, input ready);
   modport sink   (input valid, input px, input py, input last_point, output ready);
endinterface

// Result beat: one per set
interface cpmd_rsp_if import cpmd_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [DIST_FIELD_W-1:0] min_sq_dist;
   logic                    too_few;
   logic                    overflowed;

   modport source (output valid, output min_sq_dist, output too_few, output overflowed,
                   input ready);
   modport sink   (input valid, input min_sq_dist, input too_few, input overflowed,
                   output ready);
endinterface

`default_nettype wire

### hw/rtl/cpmd_ram.sv
`default_nettype none

module cpmd_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/closest_pair_min_distance_top.sv
// Channel   Dir  Beat payload                         Meaning
// req_bus   in   px, py, last_point                   one point; last_point ends the set
// rsp_bus   out  min_sq_dist, too_few, overflowed     one result per set
//
// Steps: a point that finds stored points is accepted, each stored point is read
// from the point store, the read, difference and square stages drain, then the point
// is written; the first point of a set is accepted, then written. The single read port of
// the point store sets the pace, one stored point a cycle.
// A point dropped because the store is full is not stored; only the overflow flag is set.
// The point marked last then passes through the result state.
// Reset: synchronous, active high; clears state, count, running minimum, overflow flag and result valid.
// The point store is never cleared; only entries below the count are read.
// Stalls: the result register holds a finished beat while the next set streams in;
// a new result waits only if the previous one has not yet been taken, and holds
// off the next point while it waits.
`default_nettype none

module closest_pair_min_distance_top import cpmd_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   cpmd_req_if.sink   req_bus,
   cpmd_rsp_if.source rsp_bus
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNTW  = $clog2(MAX_POINTS + 1);
   localparam int SQW   = 2 * COORD_BITS;
   localparam int DW    = SQW + 1;
   localparam int SATW  = (DW > DIST_FIELD_W) ? DW : DIST_FIELD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_STORE,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;

   logic [CNTW-1:0] count_ff, count_in;
   logic [DW-1:0]   best_ff, best_in;
   logic            ovf_ff, ovf_in;
   logic [AW-1:0]   scan_ff, scan_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DIST_FIELD_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic                    rsp_few_ff, rsp_few_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   // Latched point of the current beat
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic                  last_ff;

   // Distance pipeline
   logic                  v1_ff, v2_ff, v3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [SQW-1:0]        sqx_ff, sqy_ff;

   logic                  rd_en, wr_en;
   logic [SQW-1:0]        rd_data;
   logic [COORD_BITS-1:0] sx, sy;
   logic [DW-1:0]         sum_sq;
   logic [AW-1:0]         last_idx;
   logic [SATW-1:0]       best_wide;
   logic [DIST_FIELD_W-1:0] best_sat;
   logic                  req_take;

   cpmd_ram #(
      .WIDTH (SQW),
      .DEPTH (MAX_POINTS)
   ) u_point_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(count_ff)),
      .wr_data ({y_ff, x_ff}),
      .rd_en   (rd_en),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   assign req_bus.ready       = (state_ff == ST_IDLE);
   assign req_take            = req_bus.valid & req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.min_sq_dist = rsp_dist_ff;
   assign rsp_bus.too_few     = rsp_few_ff;
   assign rsp_bus.overflowed  = rsp_ovf_ff;

   // Stored entry: x in the low half, y in the high half
   assign sx       = rd_data[COORD_BITS-1:0];
   assign sy       = rd_data[SQW-1:COORD_BITS];
   assign sum_sq   = DW'(sqx_ff) + DW'(sqy_ff);
   assign last_idx = AW'(count_ff - CNTW'(1));

   // Saturate the minimum into the result field
   assign best_wide = SATW'(best_ff);
   assign best_sat  = (best_wide > SATW'({DIST_FIELD_W{1'b1}})) ? {DIST_FIELD_W{1'b1}}
                                                                : best_wide[DIST_FIELD_W-1:0];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      best_in      = best_ff;
      ovf_in       = ovf_ff;
      scan_in      = scan_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_bus.ready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_few_in   = rsp_few_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;

      // Fold the finished distance into the running minimum
      if (v3_ff && (sum_sq < best_ff)) begin
         best_in = sum_sq;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               if (count_ff == CNTW'(MAX_POINTS)) begin
                  // store full: drop the point, remember it
                  ovf_in   = 1'b1;
                  state_in = req_bus.last_point ? ST_RESULT : ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = ST_STORE;
               end else begin
                  scan_in  = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            rd_en   = 1'b1;
            scan_in = scan_ff + AW'(1);
            if (scan_ff == last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // the last compare lands on the edge that leaves this state
            if (!v1_ff && !v2_ff) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            wr_en    = 1'b1;
            count_in = count_ff + CNTW'(1);
            state_in = last_ff ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_few_in   = (count_ff < CNTW'(2));
               rsp_dist_in  = (count_ff < CNTW'(2)) ? '0 : best_sat;
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               best_in      = '1;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         best_ff      <= '1;
         ovf_ff       <= 1'b0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         ovf_ff       <= ovf_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_dist_ff <= rsp_dist_in;
      rsp_few_ff  <= rsp_few_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // Pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Payload: latch the point, then absolute differences, then squares
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff    <= COORD_BITS'(req_bus.px);
         y_ff    <= COORD_BITS'(req_bus.py);
         last_ff <= req_bus.last_point;
      end
      dx_ff  <= (x_ff >= sx) ? (x_ff - sx) : (sx - x_ff);
      dy_ff  <= (y_ff >= sy) ? (y_ff - sy) : (sy - y_ff);
      sqx_ff <= SQW'(dx_ff) * SQW'(dx_ff);
      sqy_ff <= SQW'(dy_ff) * SQW'(dy_ff);
   end

   // Store port is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("point store read and write overlap");

   // Count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_POINTS))
      else $error("point count beyond store depth");

   // A new result beat comes only from the result state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result beat raised outside result state");

   // No distance is still in flight when the point is written
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("store write with compares in flight");

   // Leaving the result state clears the set
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && state_in == ST_IDLE) |=> (count_ff == '0 && !ovf_ff))
      else $error("set not cleared after result");

endmodule

`default_nettype wire
